>>> sv/phpid_pkg.sv
// shared types, constants and helpers of the position hold pid core
// holds the microcode table and the symmetric clamp; no dependencies
package phpid_pkg;

    // default fraction widths of the trig inputs and of the heading angle
    localparam int TRIG_FRAC_DEF  = 14;
    localparam int ANGLE_FRAC_DEF = 12;

    // pi and 2*pi in q32, truncated
    localparam longint PI_Q32     = 64'sd13493037704;
    localparam longint TWO_PI_Q32 = 64'sd26986075409;

    // register reset values
    localparam logic [18:0] MAX_POS_ERR_RST  = 19'd4096;
    localparam logic [30:0] MAX_SPD_ERR_RST  = 31'd8388608;
    localparam logic [30:0] MAX_BANK_CMD_RST = 31'd65536;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN    = 3'd0,
        CFG_DERIV_GAIN   = 3'd1,
        CFG_INTEG_GAIN   = 3'd2,
        CFG_MAX_POS_ERR  = 3'd3,
        CFG_MAX_SPD_ERR  = 3'd4,
        CFG_MAX_BANK_CMD = 3'd5,
        CFG_HEADING_SP   = 3'd6
    } t_cfg_idx;

    // microcode program counter and entry points
    localparam int UPC_W = 4;
    localparam logic [UPC_W-1:0] UADDR_RUN   = 4'd0;
    localparam logic [UPC_W-1:0] UADDR_ENTER = 4'd14;

    typedef enum logic [2:0] {
        MA_PGAIN,
        MA_DGAIN,
        MA_IGAIN,
        MA_SIN,
        MA_COS
    } t_mul_a;

    typedef enum logic [2:0] {
        MB_ERR_X,
        MB_SPD_X,
        MB_INT_X,
        MB_ERR_Y,
        MB_SPD_Y,
        MB_INT_Y,
        MB_CMD_X,
        MB_CMD_Y
    } t_mul_b;

    typedef enum logic {
        ACC_ROLL,
        ACC_PITCH
    } t_acc_sel;

    typedef enum logic [2:0] {
        AOP_NONE,
        AOP_LOAD,
        AOP_ADD,
        AOP_LOAD_NEG,
        AOP_SUB
    } t_acc_op;

    typedef enum logic [2:0] {
        ALU_NOP,
        ALU_ERR,
        ALU_INTEG,
        ALU_CMD_X,
        ALU_CMD_Y,
        ALU_HOLD,
        ALU_OUT
    } t_alu_op;

    typedef enum logic {
        JMP_NONE,
        JMP_WAIT
    } t_jmp;

    typedef struct packed {
        t_mul_a   mul_a;
        t_mul_b   mul_b;
        t_acc_sel acc_sel;
        t_acc_op  acc_op;
        t_alu_op  alu_op;
        t_jmp     jmp;
        logic     last;
    } t_uop;

    // product of step k is in the product register at step k+1
    function automatic t_uop ucode_rom(input logic [UPC_W-1:0] addr);
        t_uop u;
        u = '{MA_PGAIN, MB_ERR_X, ACC_ROLL, AOP_NONE, ALU_NOP, JMP_NONE, 1'b1};
        case (addr)
            4'd0:  u = '{MA_PGAIN, MB_ERR_X, ACC_ROLL,  AOP_NONE,     ALU_ERR,   JMP_NONE, 1'b0};
            4'd1:  u = '{MA_PGAIN, MB_ERR_X, ACC_ROLL,  AOP_NONE,     ALU_INTEG, JMP_NONE, 1'b0};
            4'd2:  u = '{MA_PGAIN, MB_ERR_X, ACC_ROLL,  AOP_NONE,     ALU_NOP,   JMP_NONE, 1'b0};
            4'd3:  u = '{MA_DGAIN, MB_SPD_X, ACC_ROLL,  AOP_LOAD,     ALU_NOP,   JMP_NONE, 1'b0};
            4'd4:  u = '{MA_IGAIN, MB_INT_X, ACC_ROLL,  AOP_ADD,      ALU_NOP,   JMP_NONE, 1'b0};
            4'd5:  u = '{MA_PGAIN, MB_ERR_Y, ACC_ROLL,  AOP_ADD,      ALU_NOP,   JMP_NONE, 1'b0};
            4'd6:  u = '{MA_DGAIN, MB_SPD_Y, ACC_ROLL,  AOP_LOAD,     ALU_CMD_X, JMP_NONE, 1'b0};
            4'd7:  u = '{MA_IGAIN, MB_INT_Y, ACC_ROLL,  AOP_ADD,      ALU_NOP,   JMP_NONE, 1'b0};
            4'd8:  u = '{MA_SIN,   MB_CMD_X, ACC_ROLL,  AOP_ADD,      ALU_NOP,   JMP_NONE, 1'b0};
            4'd9:  u = '{MA_COS,   MB_CMD_X, ACC_ROLL,  AOP_LOAD_NEG, ALU_CMD_Y, JMP_NONE, 1'b0};
            4'd10: u = '{MA_COS,   MB_CMD_Y, ACC_PITCH, AOP_LOAD_NEG, ALU_NOP,   JMP_NONE, 1'b0};
            4'd11: u = '{MA_SIN,   MB_CMD_Y, ACC_ROLL,  AOP_ADD,      ALU_NOP,   JMP_NONE, 1'b0};
            4'd12: u = '{MA_PGAIN, MB_ERR_X, ACC_PITCH, AOP_SUB,      ALU_NOP,   JMP_NONE, 1'b0};
            4'd13: u = '{MA_PGAIN, MB_ERR_X, ACC_ROLL,  AOP_NONE,     ALU_OUT,   JMP_WAIT, 1'b1};
            UADDR_ENTER:
                   u = '{MA_PGAIN, MB_ERR_X, ACC_ROLL,  AOP_NONE,     ALU_HOLD,  JMP_NONE, 1'b1};
            default: ;
        endcase
        return u;
    endfunction

    // clamp a signed word to plus or minus a non-negative limit
    function automatic logic [31:0] clamp_sym(input logic [31:0] x, input logic [30:0] lim);
        logic signed [32:0] v;
        logic signed [32:0] l;
        logic signed [32:0] r;
        v = {x[31], x};
        l = {2'b00, lim};
        r = v;
        if (v > l) r = l;
        if (v < -l) r = -l;
        return r[31:0];
    endfunction

endpackage

>>> sv/position_hold_pid_body_rotate_core.sv
// position hold pid with body frame rotation, top level
// microcoded sequencer over one shared 32x32 multiplier; uses phpid_pkg
// heading wrap runs in a small radix-4 remainder unit beside the sequencer

// A control item (operation 0) keeps o_stall high until its program has run, so
// no new item is taken while one is in progress. The ten products of the pid and
// the rotation all go through one 32x32 multiplier, one product per microcode
// step, and the program is 14 steps long. The heading wrap runs beside the
// program; below about ANGLE_FRAC = 6 it outlasts the program, and the last
// step holds until the wrap is done. An enter item (operation 1) latches the
// hold position, clears both integrals and gives no result. The last step also
// holds while the previous result still sits unclaimed in the output register.
// Configuration writes take effect at once and are meant for idle periods. The
// sums and products wrap at 32 bits, and right shifts are arithmetic.
module position_hold_pid_body_rotate_core
    import phpid_pkg::*;
#(
    parameter int TRIG_FRAC  = TRIG_FRAC_DEF,
    parameter int ANGLE_FRAC = ANGLE_FRAC_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_operation,
    input  logic signed [31:0]    i_position_x,
    input  logic signed [31:0]    i_position_y,
    input  logic signed [31:0]    i_speed_x,
    input  logic signed [31:0]    i_speed_y,
    input  logic signed [15:0]    i_sine_heading,
    input  logic signed [15:0]    i_cosine_heading,
    input  logic signed [31:0]    i_stick_roll,
    input  logic signed [31:0]    i_stick_pitch,
    input  logic signed [31:0]    i_stick_heading,
    // output channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [31:0]    o_roll_command,
    output logic signed [31:0]    o_pitch_command,
    output logic signed [31:0]    o_heading_command
);

    // heading angle constants in q(ANGLE_FRAC)
    localparam longint ANGLE_PI     = PI_Q32 >>> (32 - ANGLE_FRAC);
    localparam longint ANGLE_TWO_PI = TWO_PI_Q32 >>> (32 - ANGLE_FRAC);
    // quotient bits of the wrap remainder, handled two per cycle
    localparam int TWO_PI_BITS = $clog2(ANGLE_TWO_PI + 1);
    localparam int Q_BITS      = 33 - TWO_PI_BITS;
    localparam int WRAP_ITERS  = (Q_BITS + 1) / 2;
    localparam int WCNT_W      = $clog2(WRAP_ITERS + 1);
    localparam logic [WCNT_W-1:0] WRAP_CNT_INIT = WCNT_W'(WRAP_ITERS);
    localparam logic [32:0] DIV_INIT = 33'(ANGLE_TWO_PI <<< (2 * WRAP_ITERS - 1));
    localparam logic signed [32:0] PI33    = 33'(ANGLE_PI);
    localparam logic signed [32:0] PI33_P1 = 33'(ANGLE_PI + 1);
    // heading = pi + rem + 1 - 2pi above the band, -pi - rem - 1 + 2pi below it
    localparam logic [31:0] HI_OFS = 32'(ANGLE_PI + 1 - ANGLE_TWO_PI);
    localparam logic [31:0] LO_OFS = 32'(ANGLE_TWO_PI - ANGLE_PI - 1);
    localparam int ROT_SHIFT = TRIG_FRAC - 2;

    // configuration registers
    logic [15:0] r_prop_gain;
    logic [15:0] r_deriv_gain;
    logic [15:0] r_integ_gain;
    logic [18:0] r_max_pos_err;
    logic [30:0] r_max_spd_err;
    logic [30:0] r_max_bank_cmd;
    logic [31:0] r_heading_sp;

    // controller state
    logic [31:0] r_hold_x;
    logic [31:0] r_hold_y;
    logic [31:0] r_integ_x;
    logic [31:0] r_integ_y;

    // sequencer
    logic             r_busy;
    logic             n_busy;
    logic [UPC_W-1:0] r_pc;
    logic [UPC_W-1:0] n_pc;
    t_uop             uop;
    logic             accept;
    logic             wait_hold;
    logic             go;

    // captured item
    logic [31:0] r_pos_x;
    logic [31:0] r_pos_y;
    logic [31:0] r_spd_in_x;
    logic [31:0] r_spd_in_y;
    logic [15:0] r_sin;
    logic [15:0] r_cos;
    logic [31:0] r_stick_roll;
    logic [31:0] r_stick_pitch;
    logic [31:0] r_head_sum;

    // datapath registers
    logic [31:0] r_err_x;
    logic [31:0] r_err_y;
    logic [31:0] r_spd_x;
    logic [31:0] r_spd_y;
    logic [31:0] r_cmd_x;
    logic [31:0] r_cmd_y;
    logic [31:0] r_prod;
    logic [31:0] r_acc_roll;
    logic [31:0] r_acc_pitch;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] prod;
    logic [31:0] acc_cur;
    logic [31:0] n_acc;
    logic [31:0] n_integ_x;
    logic [31:0] n_integ_y;

    // heading wrap unit
    logic [WCNT_W-1:0]  r_wrap_cnt;
    logic [31:0]        r_rem;
    logic [32:0]        r_div;
    logic               r_wrap_hi;
    logic               r_wrap_lo;
    logic signed [32:0] head33;
    logic               wrap_hi;
    logic               wrap_lo;
    logic [32:0]        wrap_u;
    logic [31:0]        rem_a;
    logic [32:0]        div_b;
    logic [31:0]        rem_b;
    logic [31:0]        head_out;

    // output register
    logic        r_out_valid;
    logic [31:0] r_roll_cmd;
    logic [31:0] r_pitch_cmd;
    logic [31:0] r_heading_cmd;

    assign accept  = i_valid && !o_stall;
    assign o_stall = r_busy;

    //--------------------------------------------------------------------
    // configuration
    //--------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain    <= '0;
            r_deriv_gain   <= '0;
            r_integ_gain   <= '0;
            r_max_pos_err  <= MAX_POS_ERR_RST;
            r_max_spd_err  <= MAX_SPD_ERR_RST;
            r_max_bank_cmd <= MAX_BANK_CMD_RST;
            r_heading_sp   <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_PROP_GAIN:    r_prop_gain    <= i_cfg_data[15:0];
                CFG_DERIV_GAIN:   r_deriv_gain   <= i_cfg_data[15:0];
                CFG_INTEG_GAIN:   r_integ_gain   <= i_cfg_data[15:0];
                CFG_MAX_POS_ERR:  r_max_pos_err  <= i_cfg_data[18:0];
                CFG_MAX_SPD_ERR:  r_max_spd_err  <= i_cfg_data[30:0];
                CFG_MAX_BANK_CMD: r_max_bank_cmd <= i_cfg_data[30:0];
                CFG_HEADING_SP:   r_heading_sp   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    //--------------------------------------------------------------------
    // microcode sequencer
    //--------------------------------------------------------------------
    assign uop = ucode_rom(r_pc);

    // the output step waits on the wrap unit and on a result not yet taken
    assign wait_hold = (uop.jmp == JMP_WAIT) &&
                       ((r_wrap_cnt != '0) || (r_out_valid && i_stall));
    assign go = r_busy && !wait_hold;

    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (accept) begin
            n_busy = 1'b1;
            n_pc   = i_operation ? UADDR_ENTER : UADDR_RUN;
        end else if (go) begin
            if (uop.last) begin
                n_busy = 1'b0;
            end else begin
                n_pc = r_pc + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= UADDR_RUN;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    //--------------------------------------------------------------------
    // item capture
    //--------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pos_x       <= i_position_x;
            r_pos_y       <= i_position_y;
            r_spd_in_x    <= i_speed_x;
            r_spd_in_y    <= i_speed_y;
            r_sin         <= i_sine_heading;
            r_cos         <= i_cosine_heading;
            r_stick_roll  <= i_stick_roll;
            r_stick_pitch <= i_stick_pitch;
            // user keeps setpoint stable while busy (unenforced); sum made here
            r_head_sum    <= r_heading_sp + i_stick_heading;
        end
    end

    //--------------------------------------------------------------------
    // shared multiplier, low 32 bits of the product
    //--------------------------------------------------------------------
    always_comb begin
        case (uop.mul_a)
            MA_PGAIN: mul_a = {15'b0, r_prop_gain, 1'b0};
            MA_DGAIN: mul_a = {16'b0, r_deriv_gain};
            MA_IGAIN: mul_a = {16'b0, r_integ_gain};
            MA_SIN:   mul_a = {{16{r_sin[15]}}, r_sin};
            MA_COS:   mul_a = {{16{r_cos[15]}}, r_cos};
            default:  mul_a = '0;
        endcase
    end

    always_comb begin
        case (uop.mul_b)
            MB_ERR_X: mul_b = r_err_x;
            MB_SPD_X: mul_b = $signed(r_spd_x) >>> 9;
            MB_INT_X: mul_b = $signed(r_integ_x) >>> 12;
            MB_ERR_Y: mul_b = r_err_y;
            MB_SPD_Y: mul_b = $signed(r_spd_y) >>> 9;
            MB_INT_Y: mul_b = $signed(r_integ_y) >>> 12;
            MB_CMD_X: mul_b = r_cmd_x;
            MB_CMD_Y: mul_b = r_cmd_y;
            default:  mul_b = '0;
        endcase
    end

    assign prod = mul_a * mul_b;

    // accumulator update on the product of the previous step
    assign acc_cur = (uop.acc_sel == ACC_PITCH) ? r_acc_pitch : r_acc_roll;

    always_comb begin
        case (uop.acc_op)
            AOP_LOAD:     n_acc = r_prod;
            AOP_ADD:      n_acc = acc_cur + r_prod;
            AOP_LOAD_NEG: n_acc = 32'd0 - r_prod;
            AOP_SUB:      n_acc = acc_cur - r_prod;
            default:      n_acc = acc_cur;
        endcase
    end

    // integral update, clamped to the position limit times 4096
    assign n_integ_x = clamp_sym(r_integ_x + r_err_x, {r_max_pos_err, 12'b0});
    assign n_integ_y = clamp_sym(r_integ_y + r_err_y, {r_max_pos_err, 12'b0});

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_prod <= prod;
            if (uop.acc_sel == ACC_PITCH) begin
                r_acc_pitch <= n_acc;
            end else begin
                r_acc_roll <= n_acc;
            end
            case (uop.alu_op)
                ALU_ERR: begin
                    r_err_x <= clamp_sym(r_pos_x - r_hold_x, 31'(r_max_pos_err));
                    r_err_y <= clamp_sym(r_pos_y - r_hold_y, 31'(r_max_pos_err));
                    r_spd_x <= clamp_sym(r_spd_in_x, r_max_spd_err);
                    r_spd_y <= clamp_sym(r_spd_in_y, r_max_spd_err);
                end
                ALU_CMD_X: r_cmd_x <= clamp_sym(r_acc_roll, r_max_bank_cmd);
                ALU_CMD_Y: r_cmd_y <= clamp_sym(r_acc_roll, r_max_bank_cmd);
                default: ;
            endcase
        end
    end

    // hold position and integrals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_x  <= '0;
            r_hold_y  <= '0;
            r_integ_x <= '0;
            r_integ_y <= '0;
        end else if (go) begin
            case (uop.alu_op)
                ALU_HOLD: begin
                    r_hold_x  <= r_pos_x;
                    r_hold_y  <= r_pos_y;
                    r_integ_x <= '0;
                    r_integ_y <= '0;
                end
                ALU_INTEG: begin
                    r_integ_x <= n_integ_x;
                    r_integ_y <= n_integ_y;
                end
                default: ;
            endcase
        end
    end

    //--------------------------------------------------------------------
    // heading wrap: remainder of the excess over 2pi, two quotient bits a cycle
    //--------------------------------------------------------------------
    assign head33  = {r_head_sum[31], r_head_sum};
    assign wrap_hi = head33 > PI33;
    assign wrap_lo = head33 < -PI33;
    assign wrap_u  = wrap_hi ? (head33 - PI33_P1) : (-PI33_P1 - head33);

    assign rem_a = ({1'b0, r_rem} >= r_div) ? (r_rem - r_div[31:0]) : r_rem;
    assign div_b = r_div >> 1;
    assign rem_b = ({1'b0, rem_a} >= div_b) ? (rem_a - div_b[31:0]) : rem_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_cnt <= '0;
        end else if (go && (uop.alu_op == ALU_ERR)) begin
            r_wrap_cnt <= WRAP_CNT_INIT;
        end else if (r_wrap_cnt != '0) begin
            r_wrap_cnt <= r_wrap_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && (uop.alu_op == ALU_ERR)) begin
            r_rem     <= wrap_u[31:0];
            r_div     <= DIV_INIT;
            r_wrap_hi <= wrap_hi;
            r_wrap_lo <= wrap_lo;
        end else if (r_wrap_cnt != '0) begin
            r_rem <= rem_b;
            r_div <= r_div >> 2;
        end
    end

    always_comb begin
        if (r_wrap_hi) begin
            head_out = r_rem + HI_OFS;
        end else if (r_wrap_lo) begin
            head_out = LO_OFS - r_rem;
        end else begin
            head_out = r_head_sum;
        end
    end

    //--------------------------------------------------------------------
    // output register
    //--------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (go && (uop.alu_op == ALU_OUT)) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && (uop.alu_op == ALU_OUT)) begin
            r_roll_cmd    <= 32'($signed(r_acc_roll) >>> ROT_SHIFT) + r_stick_roll;
            r_pitch_cmd   <= 32'($signed(r_acc_pitch) >>> ROT_SHIFT) + r_stick_pitch;
            r_heading_cmd <= head_out;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_roll_command    = r_roll_cmd;
    assign o_pitch_command   = r_pitch_cmd;
    assign o_heading_command = r_heading_cmd;

    //--------------------------------------------------------------------
    // assertions
    //--------------------------------------------------------------------
    // an accepted beat always starts the sequencer
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_stall)
        else $error("accepted beat did not start the sequencer");

    // the wrap unit is always done by the time the sequencer goes idle
    a_wrap_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_wrap_cnt == '0))
        else $error("heading wrap still running while idle");

    // an enter beat produces no result
    a_enter_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_operation) |=> ##1 !$rose(o_valid))
        else $error("enter beat produced a result");

    // a result only appears from a running program
    a_result_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_busy))
        else $error("result appeared without a running program");

endmodule

>>> bench/tb_position_hold_pid_body_rotate_core.sv
// testbench for position_hold_pid_body_rotate_core: directed table then random beats
// checked against an in-bench model of the hover pid; depends on phpid_pkg and the core
module tb_position_hold_pid_body_rotate_core;
    import phpid_pkg::*;

    localparam int  RESET_CYCLES   = 6;
    localparam int  SETTINGS_RUN   = 8;
    localparam int  BEATS_PER_RUN  = 240;
    localparam int  DRAIN_CYCLES   = 32;      // settling margin after the last command
    localparam int  HOLD_CYCLES    = 400;     // long receiver hold-off
    localparam int  WATCHDOG_LIMIT = 3000;
    localparam int  IDLE_PCT       = 26;
    localparam int  ROT_SHIFT      = TRIG_FRAC_DEF - 2;
    // heading half and full turn in the angle format, truncated
    localparam longint HALF_TURN   = PI_Q32 >>> (32 - ANGLE_FRAC_DEF);
    localparam longint FULL_TURN   = TWO_PI_Q32 >>> (32 - ANGLE_FRAC_DEF);

    typedef struct {
        logic               op;
        logic signed [31:0] pos_x, pos_y, spd_x, spd_y;
        logic signed [15:0] sin_h, cos_h;
        logic signed [31:0] roll_ofs, pitch_ofs, head_ofs;
    } t_beat;

    typedef struct {
        logic signed [31:0] roll, pitch, heading;
    } t_cmd;

    // one line of the directed table: a register write or an input beat
    typedef struct {
        bit          is_cfg;
        t_cfg_idx    reg_idx;
        logic [31:0] reg_val;
        t_beat       beat;
        bit          typed;
        t_cmd        want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic i_valid;
    logic o_stall;
    logic i_operation;
    logic signed [31:0] i_position_x, i_position_y, i_speed_x, i_speed_y;
    logic signed [15:0] i_sine_heading, i_cosine_heading;
    logic signed [31:0] i_stick_roll, i_stick_pitch, i_stick_heading;
    logic o_valid;
    logic i_stall;
    logic signed [31:0] o_roll_command, o_pitch_command, o_heading_command;

    // model copy of registers and state
    logic [15:0]        kp, kd, ki;
    logic [18:0]        pos_err_lim;
    logic [30:0]        spd_lim, bank_lim;
    logic signed [31:0] head_sp;
    logic signed [31:0] hold_x, hold_y, integ_x, integ_y;

    t_cmd expected_cmds[$];
    t_row dir_rows[$];

    int  errors = 0;
    int  n_beats = 0;
    int  n_enters = 0;
    int  n_results = 0;
    int  n_settings = 0;
    bit  calm = 1'b0;           // no idling on either side while set
    bit  hold_request = 1'b0;   // asks the receiver for one long hold-off

    position_hold_pid_body_rotate_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_operation       (i_operation),
        .i_position_x      (i_position_x),
        .i_position_y      (i_position_y),
        .i_speed_x         (i_speed_x),
        .i_speed_y         (i_speed_y),
        .i_sine_heading    (i_sine_heading),
        .i_cosine_heading  (i_cosine_heading),
        .i_stick_roll      (i_stick_roll),
        .i_stick_pitch     (i_stick_pitch),
        .i_stick_heading   (i_stick_heading),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_roll_command    (o_roll_command),
        .o_pitch_command   (o_pitch_command),
        .o_heading_command (o_heading_command)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- model

    // symmetric saturation against a non-negative limit
    function automatic logic signed [31:0] clip_to(logic signed [31:0] x, logic [30:0] lim);
        longint v;
        longint l;
        v = x;
        l = lim;
        if (v > l) v = l;
        if (v < -l) v = -l;
        return v[31:0];
    endfunction

    // one axis of the earth-frame pid, integral updated in place
    function automatic logic signed [31:0] axis_command(
        logic signed [31:0] pos, logic signed [31:0] hold, logic signed [31:0] spd,
        inout logic signed [31:0] integ);
        logic signed [31:0] err, sp, sp_q, integ_q, cmd;
        err     = clip_to(pos - hold, pos_err_lim);
        sp      = clip_to(spd, spd_lim);
        integ   = clip_to(integ + err, {pos_err_lim, 12'd0});
        sp_q    = sp >>> 9;
        integ_q = integ >>> 12;
        // all products wrap at 32 bits
        cmd = {15'd0, kp, 1'b0} * err + {16'd0, kd} * sp_q + {16'd0, ki} * integ_q;
        return clip_to(cmd, bank_lim);
    endfunction

    function automatic longint wrap_angle(longint v);
        if (v > HALF_TURN)
            v = v - ((v - HALF_TURN + FULL_TURN - 1) / FULL_TURN) * FULL_TURN;
        if (v < -HALF_TURN)
            v = v + ((-HALF_TURN - v + FULL_TURN - 1) / FULL_TURN) * FULL_TURN;
        return v;
    endfunction

    // returns 1 when the beat yields a command beat
    function automatic bit predict_hover_step(input t_beat b, output t_cmd c);
        logic signed [31:0] ex, ey, s32, c32, roll_pre, pitch_pre, roll_q, pitch_q, hsum;
        c = '{32'sd0, 32'sd0, 32'sd0};
        if (b.op) begin
            hold_x  = b.pos_x;
            hold_y  = b.pos_y;
            integ_x = 32'sd0;
            integ_y = 32'sd0;
            return 1'b0;
        end
        ex        = axis_command(b.pos_x, hold_x, b.spd_x, integ_x);
        ey        = axis_command(b.pos_y, hold_y, b.spd_y, integ_y);
        s32       = b.sin_h;
        c32       = b.cos_h;
        roll_pre  = (32'sd0 - s32 * ex) + c32 * ey;
        pitch_pre = 32'sd0 - (c32 * ex + s32 * ey);
        roll_q    = roll_pre >>> ROT_SHIFT;
        pitch_q   = pitch_pre >>> ROT_SHIFT;
        hsum      = head_sp + b.head_ofs;
        c.roll    = roll_q + b.roll_ofs;
        c.pitch   = pitch_q + b.pitch_ofs;
        c.heading = wrap_angle(longint'(hsum));
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------- table helpers

    function automatic t_row mk_item(logic op, logic [31:0] px, logic [31:0] py,
                                     logic [31:0] vx, logic [31:0] vy,
                                     logic [15:0] s, logic [15:0] c, logic [31:0] sr,
                                     logic [31:0] sp, logic [31:0] sh);
        t_row r;
        r.is_cfg         = 1'b0;
        r.reg_idx        = CFG_PROP_GAIN;
        r.reg_val        = '0;
        r.typed          = 1'b0;
        r.beat.op        = op;
        r.beat.pos_x     = px;
        r.beat.pos_y     = py;
        r.beat.spd_x     = vx;
        r.beat.spd_y     = vy;
        r.beat.sin_h     = s;
        r.beat.cos_h     = c;
        r.beat.roll_ofs  = sr;
        r.beat.pitch_ofs = sp;
        r.beat.head_ofs  = sh;
        return r;
    endfunction

    function automatic t_row mk_cfg(t_cfg_idx idx, logic [31:0] val);
        t_row r;
        r         = mk_item(1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        r.is_cfg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic t_row with_want(t_row r, logic [31:0] roll, logic [31:0] pitch,
                                       logic [31:0] head);
        r.typed = 1'b1;
        r.want  = '{roll, pitch, head};
        return r;
    endfunction

    // random beat, mostly near the held position so the clamps are not always hit
    function automatic t_beat gen_beat();
        t_beat b;
        int    span;
        span        = int'(pos_err_lim) * 2 + 64;
        b.op        = ($urandom_range(0, 99) < 6);
        b.pos_x     = ($urandom_range(0, 9) < 7) ? hold_x + ($urandom_range(0, 2 * span) - span)
                                                 : $urandom();
        b.pos_y     = ($urandom_range(0, 9) < 7) ? hold_y + ($urandom_range(0, 2 * span) - span)
                                                 : $urandom();
        b.spd_x     = $urandom_range(0, 1) ? $urandom_range(0, 32'h0100_0000) - 32'h0080_0000
                                           : $urandom();
        b.spd_y     = $urandom_range(0, 1) ? $urandom_range(0, 32'h0100_0000) - 32'h0080_0000
                                           : $urandom();
        b.sin_h     = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 32768) - 16384)
                                                   : 16'($urandom());
        b.cos_h     = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 32768) - 16384)
                                                   : 16'($urandom());
        b.roll_ofs  = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 200000) - 100000;
        b.pitch_ofs = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 200000) - 100000;
        b.head_ofs  = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 80000) - 40000;
        return b;
    endfunction

    // ---------------------------------------------------------------- drivers

    // one register write, then the enable drops again so enables never toggle twice in a step
    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_PROP_GAIN:    kp          = val[15:0];
            CFG_DERIV_GAIN:   kd          = val[15:0];
            CFG_INTEG_GAIN:   ki          = val[15:0];
            CFG_MAX_POS_ERR:  pos_err_lim = val[18:0];
            CFG_MAX_SPD_ERR:  spd_lim     = val[30:0];
            CFG_MAX_BANK_CMD: bank_lim    = val[30:0];
            CFG_HEADING_SP:   head_sp     = val;
            default: ;
        endcase
    endtask

    // offer one beat, return in the time step of the edge that took it
    task automatic send_beat(t_beat b, bit typed, t_cmd want);
        t_cmd got;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_operation      <= b.op;
        i_position_x     <= b.pos_x;
        i_position_y     <= b.pos_y;
        i_speed_x        <= b.spd_x;
        i_speed_y        <= b.spd_y;
        i_sine_heading   <= b.sin_h;
        i_cosine_heading <= b.cos_h;
        i_stick_roll     <= b.roll_ofs;
        i_stick_pitch    <= b.pitch_ofs;
        i_stick_heading  <= b.head_ofs;
        do @(posedge i_clk); while (o_stall);
        n_beats++;
        if (b.op) n_enters++;
        if (predict_hover_step(b, got))
            expected_cmds.push_back(typed ? want : got);
    endtask

    // drop valid, let every pending command come out, then let the core settle
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d (%h), actual %0d (%h)",
                     $time, name, $signed(want), want, $signed(got), got);
        end
    endfunction

    // ---------------------------------------------------------------- receiver

    // takes command beats, checks them, and drives the output stall
    initial begin
        int   hold_cnt;
        t_cmd want;
        hold_cnt = 0;
        i_stall  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                n_results++;
                if (expected_cmds.size() == 0) begin
                    errors++;
                    $display("%0t: command beat with nothing pending, expected none, actual %0d %0d %0d",
                             $time, o_roll_command, o_pitch_command, o_heading_command);
                end else begin
                    want = expected_cmds.pop_front();
                    compare_field("roll_command", want.roll, o_roll_command);
                    compare_field("pitch_command", want.pitch, o_pitch_command);
                    compare_field("heading_command", want.heading, o_heading_command);
                end
            end
            // hold-off is counted here so the sender keeps pushing meanwhile
            if (hold_request) begin
                hold_request = 1'b0;
                hold_cnt     = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    // ends the run when neither channel moves for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet = 0;
            else quiet++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("position_hold_pid_body_rotate_core test failed");
        $finish;
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        t_cmd        none;
        t_row        row;
        logic [15:0] g_p, g_d, g_i;
        logic [18:0] m_pos;
        logic [30:0] m_spd, m_bank;
        logic [31:0] h_sp;

        none = '{32'sd0, 32'sd0, 32'sd0};

        // every input known from time zero
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_index      <= CFG_PROP_GAIN;
        i_cfg_data       <= '0;
        i_valid          <= 1'b0;
        i_operation      <= 1'b0;
        i_position_x     <= '0;
        i_position_y     <= '0;
        i_speed_x        <= '0;
        i_speed_y        <= '0;
        i_sine_heading   <= '0;
        i_cosine_heading <= '0;
        i_stick_roll     <= '0;
        i_stick_pitch    <= '0;
        i_stick_heading  <= '0;

        // model after reset
        kp          = 16'd0;
        kd          = 16'd0;
        ki          = 16'd0;
        pos_err_lim = MAX_POS_ERR_RST;
        spd_lim     = MAX_SPD_ERR_RST;
        bank_lim    = MAX_BANK_CMD_RST;
        head_sp     = 32'sd0;
        hold_x      = 32'sd0;
        hold_y      = 32'sd0;
        integ_x     = 32'sd0;
        integ_y     = 32'sd0;

        // with all gains zero after reset the commands are just the stick offsets,
        // so these rows carry their results typed in
        dir_rows.push_back(with_want(mk_item(1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, 0));
        dir_rows.push_back(with_want(mk_item(1'b0, 32'h7fff_ffff, 32'h8000_0000,
                           32'h7fff_ffff, 32'h8000_0000, 16'sd16384, -16'sd16384,
                           32'h7fff_ffff, 32'h8000_0000, 32'sd12867),
                           32'h7fff_ffff, 32'h8000_0000, 32'sd12867));
        // just above pi wraps to just above minus pi
        dir_rows.push_back(with_want(mk_item(1'b0, 32'h8000_0000, 32'h7fff_ffff,
                           32'h8000_0000, 32'h7fff_ffff, 16'h7fff, 16'h8000,
                           0, 0, 32'sd12868), 0, 0, -32'sd12867));
        dir_rows.push_back(with_want(mk_item(1'b0, 0, 0, 0, 0, 0, 0, 0, 0, -32'sd12868),
                           0, 0, 32'sd12867));
        // far headings need many turns removed
        dir_rows.push_back(mk_item(1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h7fff_ffff));
        dir_rows.push_back(mk_item(1'b0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h8000_0000));
        // enter hover at a corner of the position range
        dir_rows.push_back(mk_item(1'b1, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_cfg(CFG_PROP_GAIN, 32'd65535));
        dir_rows.push_back(mk_cfg(CFG_DERIV_GAIN, 32'd65535));
        dir_rows.push_back(mk_cfg(CFG_INTEG_GAIN, 32'd65535));
        dir_rows.push_back(mk_cfg(CFG_MAX_POS_ERR, 32'd524287));
        dir_rows.push_back(mk_cfg(CFG_MAX_SPD_ERR, 32'h7fff_ffff));
        dir_rows.push_back(mk_cfg(CFG_MAX_BANK_CMD, 32'h7fff_ffff));
        dir_rows.push_back(mk_cfg(CFG_HEADING_SP, 32'h7fff_ffff));
        // position error wraps across the range, speeds at both ends
        dir_rows.push_back(mk_item(1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                           32'h8000_0000, 16'sd16384, -16'sd16384, 0, 0, 32'h7fff_ffff));
        // trig inputs beyond the unit range are used as given
        dir_rows.push_back(mk_item(1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                           32'h7fff_ffff, 16'h7fff, 16'h8000, 32'h7fff_ffff, 32'h8000_0000,
                           32'h8000_0000));
        dir_rows.push_back(mk_item(1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0200,
                           -32'sd512, -16'sd16384, 16'sd16384, 0, 0, 0));
        // zero error limit also pins the integral bound at zero
        dir_rows.push_back(mk_cfg(CFG_MAX_POS_ERR, 32'd0));
        dir_rows.push_back(mk_item(1'b0, 32'h1234_5678, 32'hedcb_a987, 32'h7fff_ffff,
                           32'h8000_0000, 16'sd11585, 16'sd11585, 32'sd5, -32'sd5, 32'sd100));
        dir_rows.push_back(mk_cfg(CFG_MAX_BANK_CMD, 32'd0));
        dir_rows.push_back(mk_item(1'b0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                           32'h8000_0000, 16'h7fff, 16'h8000, 32'sd1, 32'sd2, 32'sd3));
        dir_rows.push_back(mk_item(1'b1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk_item(1'b0, 32'sd3, -32'sd3, 32'sd1024, -32'sd1024,
                           16'sd8192, -16'sd8192, 0, 0, -32'sd1));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (dir_rows[k]) begin
            row = dir_rows[k];
            if (row.is_cfg) begin
                wait_idle();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                send_beat(row.beat, row.typed, row.typed ? row.want : none);
            end
        end
        n_settings++;

        // random part, one register setting per run
        for (int run = 0; run < SETTINGS_RUN; run++) begin
            wait_idle();
            case (run)
                0: begin
                    // small gains, limits back at their reset values
                    g_p    = $urandom_range(0, 255);
                    g_d    = $urandom_range(0, 255);
                    g_i    = $urandom_range(0, 255);
                    m_pos  = MAX_POS_ERR_RST;
                    m_spd  = MAX_SPD_ERR_RST;
                    m_bank = MAX_BANK_CMD_RST;
                    h_sp   = 32'd0;
                end
                1: begin
                    g_p    = 16'hffff;
                    g_d    = 16'hffff;
                    g_i    = 16'hffff;
                    m_pos  = 19'h7ffff;
                    m_spd  = 31'h7fff_ffff;
                    m_bank = 31'h7fff_ffff;
                    h_sp   = 32'h7fff_ffff;
                end
                2: begin
                    g_p    = 16'd0;
                    g_d    = 16'd0;
                    g_i    = 16'd0;
                    m_pos  = 19'd0;
                    m_spd  = 31'd0;
                    m_bank = 31'd0;
                    h_sp   = 32'h8000_0000;
                end
                default: begin
                    g_p    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                         : $urandom_range(0, 512);
                    g_d    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                         : $urandom_range(0, 512);
                    g_i    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                         : $urandom_range(0, 512);
                    m_pos  = $urandom_range(0, 1) ? $urandom_range(0, 524287)
                                                  : $urandom_range(0, 8192);
                    m_spd  = $urandom_range(0, 1) ? 31'($urandom() >> 1)
                                                  : 31'($urandom_range(0, 32'h0100_0000));
                    m_bank = $urandom_range(0, 1) ? 31'($urandom() >> 1)
                                                  : 31'($urandom_range(0, 32'h0010_0000));
                    h_sp   = $urandom();
                end
            endcase
            write_reg(CFG_PROP_GAIN, {16'd0, g_p});
            write_reg(CFG_DERIV_GAIN, {16'd0, g_d});
            write_reg(CFG_INTEG_GAIN, {16'd0, g_i});
            write_reg(CFG_MAX_POS_ERR, {13'd0, m_pos});
            write_reg(CFG_MAX_SPD_ERR, {1'b0, m_spd});
            write_reg(CFG_MAX_BANK_CMD, {1'b0, m_bank});
            write_reg(CFG_HEADING_SP, h_sp);
            n_settings++;

            // run 1 goes without idling, run 3 carries the long output hold-off
            calm = (run == 1);
            if (run == 3) hold_request = 1'b1;

            // every run starts from a fresh hover entry so most steps see small errors
            send_beat(mk_item(1'b1, $urandom(), $urandom(), 0, 0, 0, 0, 0, 0, 0).beat,
                      1'b0, none);
            for (int n = 1; n < BEATS_PER_RUN; n++)
                send_beat(gen_beat(), 1'b0, none);
        end
        calm = 1'b0;

        wait_idle();
        $display("ran %0d input beats (%0d hover entries) over %0d register settings",
                 n_beats, n_enters, n_settings);
        $display("checked %0d command beats, %0d mismatches", n_results, errors);
        if (errors == 0)
            $display("position_hold_pid_body_rotate_core test passed");
        else
            $display("position_hold_pid_body_rotate_core test failed");
        $finish;
    end

endmodule
